### design/utlm_pkg.sv
// shared types, constants and helpers for the ultrasonic tank level meter
package utlm_pkg;

  // default tick counter width
  localparam int unsigned COUNTER_WIDTH = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_US_PER_TICK    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TANK_HEIGHT_CM = 3'd4;

  // register reset values
  localparam logic [7:0]  RST_US_PER_TICK    = 8'd10;
  localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd3000;
  localparam logic [7:0]  RST_TRIGGER_TICKS  = 8'd1;
  localparam logic [15:0] RST_GAP_TICKS      = 16'd1000;
  localparam logic [7:0]  RST_TANK_HEIGHT_CM = 8'd100;

  // distance conversion: cm = us / 58, saturated at 254
  localparam int unsigned SOUND_DIV = 58;
  localparam logic [7:0]  DIST_MAX  = 8'd254;
  localparam logic [7:0]  FAIL_DIST = 8'hFF;
  // smallest echo product in us that saturates the distance
  localparam int unsigned ACC_W     = 14;
  localparam logic [ACC_W-1:0] ACC_SAT = ACC_W'(255 * SOUND_DIV);
  // reciprocal of 58, exact for every product below ACC_SAT
  localparam int unsigned RECIP_SH  = 20;
  localparam int unsigned RECIP_W   = 15;
  localparam logic [RECIP_W-1:0] RECIP_K =
    RECIP_W'(((1 << RECIP_SH) + SOUND_DIV - 1) / SOUND_DIV);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TRIG = 5'b00010,
    PH_WAIT = 5'b00100,
    PH_HIGH = 5'b01000,
    PH_GAP  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic       trigger_out;
    logic       busy_res;
    logic       result_valid;
    logic [7:0] water_level_cm;
    logic       measure_error;
  } result_t;

  function automatic logic [7:0] mid3(input logic [7:0] x, input logic [7:0] y,
                                      input logic [7:0] z);
    logic [7:0] m;
    if ((x <= y && y <= z) || (z <= y && y <= x)) begin
      m = y;
    end else if ((y <= x && x <= z) || (z <= x && x <= y)) begin
      m = x;
    end else begin
      m = z;
    end
    return m;
  endfunction

endpackage

### design/ultrasonic_tank_level_meter_top.sv
// ultrasonic tank level meter: three echo readings, median, level result
//
// usage
//   input channel: one beat per tick, carrying start_req and the sampled echo
//   level; in_valid_i / in_stall_o. output channel: exactly one result beat
//   per input beat, in order; out_valid_o / out_stall_i.
//   a start request in idle launches three ranging readings separated by
//   gap_ticks; each drives the trigger, waits for echo high and counts the
//   echo-high ticks, both with a timeout. the beat on which the third reading
//   ends carries result_valid with the level, or measure_error on a timeout.
//   configuration (cfg_we_i, cfg_idx_i, cfg_data_i) is written while idle.
// timing
//   one input beat per cycle sustained while in_stall_o is low; a result is
//   registered once its input beat is taken. all work for a beat sits between the
//   input state and the output register: counter compares, one constant
//   multiply for the divide by 58 and the median select.
// reset
//   state goes idle, configuration returns to its defaults, both output slots
//   empty. when the receiver stalls, the output register holds its beat and a
//   skid slot takes one more; in_stall_o rises only once the skid slot is full.
module ultrasonic_tank_level_meter_top #(
  parameter int unsigned COUNTER_WIDTH = utlm_pkg::COUNTER_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration port
  input  logic                           cfg_we_i,
  input  logic [utlm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [utlm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           start_req_i,
  input  logic                           echo_level_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           trigger_out_o,
  output logic                           busy_res_o,
  output logic                           result_valid_o,
  output logic [7:0]                     water_level_cm_o,
  output logic                           measure_error_o
);
  import utlm_pkg::*;

  localparam int unsigned CW = COUNTER_WIDTH;
  // compare width: holds a counter plus one and any 16 bit limit
  localparam int unsigned WW = (CW + 1 > 17) ? CW + 1 : 17;
  localparam logic [WW-1:0] CNT_MAX = {{(WW - CW){1'b0}}, {CW{1'b1}}};

  // configuration registers
  logic [7:0]  us_per_tick_q;
  logic [15:0] timeout_ticks_q;
  logic [7:0]  trigger_ticks_q;
  logic [15:0] gap_ticks_q;
  logic [7:0]  tank_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      us_per_tick_q   <= RST_US_PER_TICK;
      timeout_ticks_q <= RST_TIMEOUT_TICKS;
      trigger_ticks_q <= RST_TRIGGER_TICKS;
      gap_ticks_q     <= RST_GAP_TICKS;
      tank_height_q   <= RST_TANK_HEIGHT_CM;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_US_PER_TICK:    us_per_tick_q   <= cfg_data_i[7:0];
        CFG_TIMEOUT_TICKS:  timeout_ticks_q <= cfg_data_i[15:0];
        CFG_TRIGGER_TICKS:  trigger_ticks_q <= cfg_data_i[7:0];
        CFG_GAP_TICKS:      gap_ticks_q     <= cfg_data_i[15:0];
        CFG_TANK_HEIGHT_CM: tank_height_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  phase_e          phase_q, phase_d;
  logic [CW-1:0]   tick_q, tick_d;
  logic [1:0]      ridx_q, ridx_d;
  logic            any_to_q, any_to_d;
  // running echo product tick * us_per_tick, saturated at ACC_SAT
  logic [ACC_W-1:0] acc_q, acc_d;
  // distance per reading, written before it is read
  logic [7:0]      dist_q [3];
  logic [7:0]      dist_d [3];

  // output register and skid slot
  result_t out_q, skid_q, res_d;
  logic    out_vld_q, skid_vld_q;

  logic in_acc, out_ready;
  assign in_acc    = in_valid_i && !skid_vld_q;
  assign out_ready = !out_vld_q || !out_stall_i;

  // limits clamped to what the counter can hold
  logic [WW-1:0] tick_w, tick_inc, tick_sat, timeout_w, gap_w, lim, gap_lim, trig_len;
  assign tick_w    = WW'(tick_q);
  assign tick_inc  = tick_w + WW'(1);
  assign tick_sat  = (tick_inc > CNT_MAX) ? CNT_MAX : tick_inc;
  assign timeout_w = WW'(timeout_ticks_q);
  assign gap_w     = WW'(gap_ticks_q);
  assign lim       = (timeout_w > CNT_MAX) ? CNT_MAX : timeout_w;
  assign gap_lim   = (gap_w > CNT_MAX) ? CNT_MAX : gap_w;
  // a zero trigger length acts as one tick
  assign trig_len  = (trigger_ticks_q == 8'd0) ? WW'(1) : WW'(trigger_ticks_q);

  // echo product to centimeters through the reciprocal of 58
  logic [ACC_W+RECIP_W-1:0] recip_prod;
  logic [7:0]               echo_dist;
  logic [ACC_W:0]           acc_sum;
  assign recip_prod = (ACC_W + RECIP_W)'(acc_q) * (ACC_W + RECIP_W)'(RECIP_K);
  assign echo_dist  = (acc_q >= ACC_SAT) ? DIST_MAX : recip_prod[RECIP_SH +: 8];
  assign acc_sum    = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(us_per_tick_q);

  logic       fin, fin_fail, done;
  logic [7:0] fin_dist, med;
  logic [1:0] fin_idx;

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    ridx_d   = ridx_q;
    any_to_d = any_to_q;
    acc_d    = acc_q;
    dist_d   = dist_q;
    fin      = 1'b0;
    fin_fail = 1'b0;
    fin_dist = FAIL_DIST;
    done     = 1'b0;
    med      = 8'd0;
    res_d    = '0;

    res_d.busy_res = (phase_q != PH_IDLE);

    case (phase_q)
      PH_IDLE: begin
        if (start_req_i) begin
          phase_d  = PH_TRIG;
          tick_d   = '0;
          ridx_d   = 2'd0;
          any_to_d = 1'b0;
        end
      end
      PH_TRIG: begin
        res_d.trigger_out = 1'b1;
        tick_d = tick_sat[CW-1:0];
        if (tick_sat >= trig_len) begin
          tick_d  = '0;
          phase_d = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (echo_level_i) begin
          // the first high tick already counts
          phase_d = PH_HIGH;
          if (WW'(1) > lim) begin
            fin      = 1'b1;
            fin_fail = 1'b1;
          end else begin
            tick_d = CW'(1);
            acc_d  = ACC_W'(us_per_tick_q);
          end
        end else if (tick_inc > lim) begin
          fin      = 1'b1;
          fin_fail = 1'b1;
        end else begin
          tick_d = tick_inc[CW-1:0];
        end
      end
      PH_HIGH: begin
        if (echo_level_i) begin
          if (tick_inc > lim) begin
            fin      = 1'b1;
            fin_fail = 1'b1;
          end else begin
            tick_d = tick_inc[CW-1:0];
            acc_d  = (acc_sum >= (ACC_W + 1)'(ACC_SAT)) ? ACC_SAT : acc_sum[ACC_W-1:0];
          end
        end else begin
          fin      = 1'b1;
          fin_dist = echo_dist;
        end
      end
      PH_GAP: begin
        tick_d = tick_sat[CW-1:0];
        if (tick_sat >= gap_lim) begin
          tick_d  = '0;
          phase_d = PH_TRIG;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
        ridx_d  = 2'd0;
      end
    endcase

    // end of one reading
    fin_idx = (ridx_q == 2'd3) ? 2'd2 : ridx_q;
    if (fin) begin
      dist_d[fin_idx] = fin_dist;
      if (fin_fail) begin
        any_to_d = 1'b1;
      end
      tick_d = '0;
      if (fin_idx == 2'd2) begin
        phase_d = PH_IDLE;
        ridx_d  = 2'd0;
        done    = 1'b1;
      end else begin
        ridx_d  = fin_idx + 2'd1;
        phase_d = (gap_ticks_q == 16'd0) ? PH_TRIG : PH_GAP;
      end
    end

    if (done) begin
      res_d.result_valid  = 1'b1;
      res_d.measure_error = any_to_d;
      if (!any_to_d) begin
        med = mid3(dist_d[0], dist_d[1], dist_d[2]);
        res_d.water_level_cm = (med >= tank_height_q) ? 8'd0 : (tank_height_q - med);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      tick_q   <= '0;
      ridx_q   <= 2'd0;
      any_to_q <= 1'b0;
    end else if (in_acc) begin
      phase_q  <= phase_d;
      tick_q   <= tick_d;
      ridx_q   <= ridx_d;
      any_to_q <= any_to_d;
    end
  end

  // payload state, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      acc_q  <= acc_d;
      dist_q <= dist_d;
    end
  end

  // output register with one skid slot behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_ready) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= in_acc;
      end
    end else if (in_acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res_d;
      end
    end else if (in_acc) begin
      skid_q <= res_d;
    end
  end

  assign in_stall_o       = skid_vld_q;
  assign out_valid_o      = out_vld_q;
  assign trigger_out_o    = out_q.trigger_out;
  assign busy_res_o       = out_q.busy_res;
  assign result_valid_o   = out_q.result_valid;
  assign water_level_cm_o = out_q.water_level_cm;
  assign measure_error_o  = out_q.measure_error;

endmodule

### test/level_meter_check.sv
// checker for the tank level meter: tracks the meter state, predicts every result beat, compares
module level_meter_check #(
  parameter int unsigned CNT_W = utlm_pkg::COUNTER_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [utlm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [utlm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic                            start_req_i,
  input  logic                            echo_level_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic                            trigger_out_i,
  input  logic                            busy_res_i,
  input  logic                            result_valid_i,
  input  logic [7:0]                      water_level_cm_i,
  input  logic                            measure_error_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output logic                            meter_idle_o,
  output int                              results_o,
  output int                              levels_o,
  output int                              timeouts_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import utlm_pkg::*;

  localparam longint unsigned CM_DIVISOR = 58;
  localparam logic [7:0]      RANGE_CAP  = 8'd254;
  localparam logic [7:0]      BAD_RANGE  = 8'hFF;

  // register copies
  logic [7:0]  r_us;
  logic [15:0] r_tmo;
  logic [7:0]  r_trig;
  logic [15:0] r_gap;
  logic [7:0]  r_height;

  // meter state
  phase_e          ph;
  longint unsigned ticks;
  int unsigned     ridx;
  logic [7:0]      ranges [3];
  logic            any_to;

  result_t meter_out_q [$];
  result_t want;
  result_t got;
  logic    bad;
  int      fail_count = 0;
  int      results    = 0;
  int      levels     = 0;
  int      timeouts   = 0;

  function automatic longint unsigned cnt_lim(input longint unsigned v);
    longint unsigned top_val;
    top_val = (longint'(1) << CNT_W) - 1;
    return (v > top_val) ? top_val : v;
  endfunction

  function automatic logic [7:0] median_of(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (c <= lo) ? lo : ((c >= hi) ? hi : c);
  endfunction

  // closes a reading, returns 1 when it was the third one
  function automatic logic end_reading(input logic [7:0] range_cm, input logic failed);
    int unsigned idx;
    idx = (ridx > 2) ? 2 : ridx;
    ranges[idx] = range_cm;
    if (failed) any_to = 1'b1;
    ticks = 0;
    if (idx >= 2) begin
      ph = PH_IDLE;
      ridx = 0;
      return 1'b1;
    end
    ridx = idx + 1;
    ph = (r_gap == 16'd0) ? PH_TRIG : PH_GAP;
    return 1'b0;
  endfunction

  function automatic logic echo_high(input logic echo);
    longint unsigned d;
    if (echo) begin
      if (ticks + 1 > cnt_lim(64'(r_tmo))) return end_reading(BAD_RANGE, 1'b1);
      ticks = ticks + 1;
      return 1'b0;
    end
    d = (ticks * 64'(r_us)) / CM_DIVISOR;
    if (d > RANGE_CAP) d = RANGE_CAP;
    return end_reading(d[7:0], 1'b0);
  endfunction

  function automatic result_t meter_tick(input logic start, input logic echo);
    result_t r;
    logic done;
    longint unsigned len;
    logic [7:0] m;
    r = '0;
    done = 1'b0;
    r.busy_res = (ph != PH_IDLE);
    case (ph)
      PH_IDLE: begin
        if (start) begin
          ph = PH_TRIG;
          ticks = 0;
          ridx = 0;
          any_to = 1'b0;
        end
      end
      PH_TRIG: begin
        len = (r_trig == 8'd0) ? 64'd1 : 64'(r_trig);
        r.trigger_out = 1'b1;
        ticks = cnt_lim(ticks + 1);
        if (ticks >= cnt_lim(len)) begin
          ticks = 0;
          ph = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          ticks = 0;
          ph = PH_HIGH;
          done = echo_high(1'b1);
        end else if (ticks + 1 > cnt_lim(64'(r_tmo))) begin
          done = end_reading(BAD_RANGE, 1'b1);
        end else begin
          ticks = ticks + 1;
        end
      end
      PH_HIGH: done = echo_high(echo);
      PH_GAP: begin
        ticks = cnt_lim(ticks + 1);
        if (ticks >= cnt_lim(64'(r_gap))) begin
          ticks = 0;
          ph = PH_TRIG;
        end
      end
      default: begin
        ph = PH_IDLE;
        ticks = 0;
        ridx = 0;
      end
    endcase
    if (done) begin
      r.result_valid = 1'b1;
      r.measure_error = any_to;
      if (!any_to) begin
        m = median_of(ranges[0], ranges[1], ranges[2]);
        r.water_level_cm = (m >= r_height) ? 8'd0 : r_height - m;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_us = 8'd10;
      r_tmo = 16'd3000;
      r_trig = 8'd1;
      r_gap = 16'd1000;
      r_height = 8'd100;
      ph = PH_IDLE;
      ticks = 0;
      ridx = 0;
      any_to = 1'b0;
      ranges[0] = '0;
      ranges[1] = '0;
      ranges[2] = '0;
      meter_out_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_US_PER_TICK:    r_us = cfg_data_i[7:0];
          CFG_TIMEOUT_TICKS:  r_tmo = cfg_data_i;
          CFG_TRIGGER_TICKS:  r_trig = cfg_data_i[7:0];
          CFG_GAP_TICKS:      r_gap = cfg_data_i;
          CFG_TANK_HEIGHT_CM: r_height = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        meter_out_q.push_back(meter_tick(start_req_i, echo_level_i));
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{trigger_out_i, busy_res_i, result_valid_i, water_level_cm_i,
                measure_error_i};
        results++;
        if (meter_out_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result beat %0d arrived with none pending", results);
        end else begin
          want = meter_out_q.pop_front();
          bad = (got.trigger_out !== want.trigger_out) ||
                (got.busy_res !== want.busy_res) ||
                (got.result_valid !== want.result_valid) ||
                (got.water_level_cm !== want.water_level_cm) ||
                (got.measure_error !== want.measure_error);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result beat %0d: want trig=%b busy=%b valid=%b level=%0d err=%b",
                       results, want.trigger_out, want.busy_res, want.result_valid,
                       want.water_level_cm, want.measure_error);
              $display("result beat %0d:  got trig=%b busy=%b valid=%b level=%0d err=%b",
                       results, got.trigger_out, got.busy_res, got.result_valid,
                       got.water_level_cm, got.measure_error);
            end
          end
          if (want.result_valid && want.measure_error) timeouts++;
          else if (want.result_valid) levels++;
        end
      end
    end
    fail_count_o = fail_count;
    pending_o = meter_out_q.size();
    meter_idle_o = (ph == PH_IDLE);
    results_o = results;
    levels_o = levels;
    timeouts_o = timeouts;
  end

endmodule

### test/testbench.sv
// testbench top: feeds echo tick streams and register settings to the tank level meter
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import utlm_pkg::*;

  // receiver hold-off long enough to fill both output slots and back up the input
  localparam int LONG_HOLD = 64;
  // index with no register behind it, the meter must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  start_req;
  logic                  echo_level;
  logic                  out_valid;
  logic                  out_stall;
  logic                  trigger_out;
  logic                  busy_res;
  logic                  result_valid;
  logic [7:0]            water_level_cm;
  logic                  measure_error;

  int   fail_count;
  int   pending;
  logic meter_idle;
  int   results;
  int   levels;
  int   timeouts;

  // echo waveform shaping: alternating low/high runs, mostly within the timeout
  logic echo_now = 1'b0;
  int   echo_left = 0;
  int   run_cap = 1;
  int   long_pct = 0;
  int   tmo_now = 3000;

  bit idling = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int settings = 1;
  int stall_left = 0;

  ultrasonic_tank_level_meter_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .start_req_i      (start_req),
    .echo_level_i     (echo_level),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .trigger_out_o    (trigger_out),
    .busy_res_o       (busy_res),
    .result_valid_o   (result_valid),
    .water_level_cm_o (water_level_cm),
    .measure_error_o  (measure_error)
  );

  level_meter_check u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .start_req_i      (start_req),
    .echo_level_i     (echo_level),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .trigger_out_i    (trigger_out),
    .busy_res_i       (busy_res),
    .result_valid_i   (result_valid),
    .water_level_cm_i (water_level_cm),
    .measure_error_i  (measure_error),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .meter_idle_o     (meter_idle),
    .results_o        (results),
    .levels_o         (levels),
    .timeouts_o       (timeouts)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // next echo level: flip at the end of each run, then pick a new run length;
  // an occasional run past the timeout makes the reading fail
  function automatic logic next_echo();
    if (echo_left == 0) begin
      echo_now = ~echo_now;
      if ($urandom_range(0, 99) < long_pct) echo_left = tmo_now + $urandom_range(1, 3);
      else echo_left = $urandom_range(1, run_cap);
    end
    echo_left--;
    return echo_now;
  endfunction

  // one input beat: optional idle burst first, then hold the beat until taken
  task automatic send_beat(input logic start, input logic echo);
    int pause;
    if (idling && $urandom_range(0, 7) == 0) begin
      pause = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_valid <= 1'b1;
    start_req <= start;
    echo_level <= echo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // keep ticking without start until the meter is idle, then let the output drain
  task automatic settle();
    while (!meter_idle) send_beat(1'b0, next_echo());
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
  endtask

  // full register set, only called with the meter idle and nothing pending
  task automatic load_config(input logic [7:0] us, input logic [15:0] tmo,
                             input logic [7:0] trig, input logic [15:0] gap,
                             input logic [7:0] height);
    write_reg(CFG_US_PER_TICK, 16'(us));
    write_reg(CFG_TIMEOUT_TICKS, tmo);
    write_reg(CFG_TRIGGER_TICKS, 16'(trig));
    write_reg(CFG_GAP_TICKS, gap);
    write_reg(CFG_TANK_HEIGHT_CM, 16'(height));
    cfg_we <= 1'b0;
    tmo_now = int'(tmo);
    settings++;
  endtask

  // a burst of beats with random start requests; the first beat always starts
  task automatic run_phase(input int beats, input int start_pct, input int cap,
                           input int lpct, input bit idle_on, input bit with_hold);
    idling = idle_on;
    run_cap = cap;
    long_pct = lpct;
    for (int i = 0; i < beats; i++) begin
      if (with_hold && i == 40) hold_req = 1'b1;
      send_beat(i == 0 || $urandom_range(0, 99) < start_pct, next_echo());
    end
    settle();
  endtask

  // receiver: random stall bursts, plus one long hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0) begin
        if (hold_req && !hold_done) begin
          hold_done = 1'b1;
          stall_left = LONG_HOLD;
        end else if (idling && $urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(1, 11);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    int us;
    int tmo;
    int trig;
    int gap;
    int height;
    int cap;
    int lpct;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    start_req = 1'b0;
    echo_level = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values except a short gap: one full measurement
    write_reg(CFG_GAP_TICKS, 16'd8);
    cfg_we <= 1'b0;
    run_phase(20, 50, 40, 0, 1'b1, 1'b0);

    // largest tick weight, timeout and height; long echoes saturate the distance
    load_config(8'd255, 16'hFFFF, 8'd20, 16'd8, 8'd255);
    run_phase(10, 50, 80, 0, 1'b1, 1'b0);

    // a write to an empty index changes nothing
    write_reg(CFG_NO_REG, 16'hFFFF);
    cfg_we <= 1'b0;
    @(negedge clk);

    // bottom values: zero-length trigger, no gap, empty tank, one-tick timeout
    load_config(8'd1, 16'd1, 8'd0, 16'd0, 8'd0);
    run_phase(60, 60, 1, 30, 1'b1, 1'b0);

    // one cm per tick, no gap, height often at or below the median
    load_config(8'd58, 16'd6, 8'd1, 16'd0, 8'd3);
    run_phase(80, 40, 6, 10, 1'b1, 1'b0);

    // random settings and echo patterns, quiet interface in the last one
    for (int k = 0; k < 8; k++) begin
      us = $urandom_range(1, 255);
      trig = $urandom_range(1, 5);
      gap = $urandom_range(0, 12);
      height = $urandom_range(0, 255);
      if ($urandom_range(0, 3) == 0) begin
        tmo = $urandom_range(31, 2000);
        cap = 60;
        lpct = 0;
      end else begin
        tmo = $urandom_range(1, 30);
        cap = tmo;
        lpct = $urandom_range(0, 15);
      end
      load_config(8'(us), 16'(tmo), 8'(trig), 16'(gap), 8'(height));
      run_phase(80, 30, cap, lpct, k != 7 && $urandom_range(0, 3) != 0, k == 2);
    end

    idling = 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk);
    $display("covered %0d result beats over %0d register settings", results, settings);
    $display("completed measurements: %0d with a level, %0d with a timeout", levels, timeouts);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
